// ----- hdl/dsrc_pkg.sv -----
// shared constants, result record type, crc byte step and saturating increment for the sector record checker
// no dependencies
`default_nettype none

package dsrc_pkg;

    localparam int NUM_TRACKS        = 80;
    localparam int SECTORS_PER_TRACK = 16;
    localparam int SECTOR_BYTES      = 256;
    localparam int HEADER_BYTES      = 66;

    localparam int CRC_SPAN    = 4 + SECTOR_BYTES;
    localparam int POS_W       = $clog2(CRC_SPAN + 2);
    localparam int TRACK_IDX_W = $clog2(NUM_TRACKS);

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [7:0] FMT_FORMATTED = 8'h04;
    localparam logic [7:0] FMT_PROTECTED = 8'h44;

    localparam logic [7:0] HDR_CHAR0   = 8'h53;
    localparam logic [7:0] HDR_CHAR1   = 8'h41;
    localparam logic [7:0] HDR_CHAR2   = 8'h50;
    localparam logic [7:0] HDR_VER_ONE = 8'h01;
    localparam logic [7:0] HDR_VER_TWO = 8'h02;

    localparam logic [1:0] EV_COUNTED  = 2'd0;
    localparam logic [1:0] EV_SKIPPED  = 2'd1;
    localparam logic [1:0] EV_REJECTED = 2'd2;
    localparam logic [1:0] EV_SUMMARY  = 2'd3;

    localparam logic [6:0] TRACKS_MAX = 7'h7F;

    typedef struct packed {
        logic [1:0]  ev;
        logic [7:0]  track;
        logic [7:0]  sector;
        logic [7:0]  fmt;
        logic [7:0]  prot;
        logic [15:0] crc;
        logic        ok;
        logic [15:0] total;
        logic [15:0] valid;
        logic [15:0] formatted;
        logic [6:0]  tracks;
        logic        last;
    } result_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

    function automatic logic [15:0] sat_inc16(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/disk_image_sector_record_checker_unit.sv -----
// sector record checker: header check, per-record crc-16 and saturating image totals
// depends on dsrc_pkg
// results: the results of a beat are written into the result queue when the beat is accepted,
// a second result (record end together with image end) goes in with the first and follows it at the output
// throughput: one input beat per cycle; input stalls while three or more results are queued
// reset: state and queue cleared; track map wiped by a background pass over all 80 entries
`default_nettype none

module disk_image_sector_record_checker_unit
    import dsrc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        end_of_image,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       event_res,
    output logic [7:0]       track_number,
    output logic [7:0]       sector_number,
    output logic [7:0]       format_code,
    output logic [7:0]       protection_flags,
    output logic [15:0]      computed_crc,
    output logic             crc_ok,
    output logic [15:0]      sectors_total,
    output logic [15:0]      sectors_valid,
    output logic [15:0]      sectors_formatted,
    output logic [6:0]       tracks_used,
    output logic             last_of_run
);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_RECORDS,
        PH_REJECTED
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [POS_W-1:0]       pos_reg, pos_next;
    logic                   header_ok_reg, header_ok_next;
    logic [15:0]            crc_reg, crc_next;
    logic [7:0]             fmt_reg, fmt_next;
    logic [7:0]             prot_reg, prot_next;
    logic [7:0]             track_reg, track_next;
    logic [7:0]             sector_reg, sector_next;
    logic [7:0]             crc_hi_reg, crc_hi_next;
    logic [15:0]            total_reg, total_next;
    logic [15:0]            valid_reg, valid_next;
    logic [15:0]            formatted_reg, formatted_next;
    logic [6:0]             used_reg, used_next;

    logic                   seen_mem [NUM_TRACKS];
    logic                   seen_rd_reg;
    logic                   seen_set;
    logic                   clr_active_reg, clr_active_next;
    logic [TRACK_IDX_W-1:0] clr_idx_reg, clr_idx_next;

    result_t                fifo_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0]  cnt_reg, cnt_next;

    logic                   in_fire;
    logic                   out_fire;
    logic [1:0]             push_cnt;
    result_t                res_a;
    result_t                res_b;
    result_t                res_sum;
    result_t                head;
    logic [15:0]            stored_crc;
    logic                   rec_ok;
    logic                   rec_bad;
    logic                   hdr_ok_now;

    assign in_stall = (cnt_reg >= FIFO_CNT_W'(FIFO_DEPTH - 1));
    assign in_fire  = in_valid && !in_stall;
    assign out_valid = (cnt_reg != '0);
    assign out_fire  = out_valid && !out_stall;

    assign stored_crc = {crc_hi_reg, data_byte};
    assign rec_ok     = (stored_crc == crc_reg);
    assign rec_bad    = (track_reg >= 8'(NUM_TRACKS)) || (sector_reg < 8'd1)
                        || (sector_reg > 8'(SECTORS_PER_TRACK));

    always_comb
    begin
        phase_next      = phase_reg;
        pos_next        = pos_reg;
        header_ok_next  = header_ok_reg;
        crc_next        = crc_reg;
        fmt_next        = fmt_reg;
        prot_next       = prot_reg;
        track_next      = track_reg;
        sector_next     = sector_reg;
        crc_hi_next     = crc_hi_reg;
        total_next      = total_reg;
        valid_next      = valid_reg;
        formatted_next  = formatted_reg;
        used_next       = used_reg;
        seen_set        = 1'b0;
        clr_active_next = clr_active_reg;
        clr_idx_next    = clr_idx_reg;
        res_a           = '0;
        res_b           = '0;
        res_sum         = '0;
        push_cnt        = 2'd0;
        hdr_ok_now      = header_ok_reg;

        // track map wipe, one entry per cycle
        if (clr_active_reg)
        begin
            if (clr_idx_reg == TRACK_IDX_W'(NUM_TRACKS - 1))
                clr_active_next = 1'b0;
            else
                clr_idx_next = clr_idx_reg + TRACK_IDX_W'(1);
        end

        if (in_fire)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (pos_reg == POS_W'(0) && data_byte != HDR_CHAR0)
                        hdr_ok_now = 1'b0;
                    if (pos_reg == POS_W'(1) && data_byte != HDR_CHAR1)
                        hdr_ok_now = 1'b0;
                    if (pos_reg == POS_W'(2) && data_byte != HDR_CHAR2)
                        hdr_ok_now = 1'b0;
                    if (pos_reg == POS_W'(3) && data_byte != HDR_VER_ONE
                        && data_byte != HDR_VER_TWO)
                        hdr_ok_now = 1'b0;
                    header_ok_next = hdr_ok_now;
                    if (pos_reg >= POS_W'(HEADER_BYTES - 1))
                    begin
                        pos_next = '0;
                        crc_next = CRC_INIT;
                        if (hdr_ok_now)
                        begin
                            phase_next = PH_RECORDS;
                            if (end_of_image)
                            begin
                                res_a.ev        = EV_SUMMARY;
                                res_a.total     = total_reg;
                                res_a.valid     = valid_reg;
                                res_a.formatted = formatted_reg;
                                res_a.tracks    = used_reg;
                                push_cnt        = 2'd1;
                            end
                        end
                        else
                        begin
                            phase_next = PH_REJECTED;
                            res_a.ev   = EV_REJECTED;
                            push_cnt   = 2'd1;
                        end
                    end
                    else
                    begin
                        pos_next = pos_reg + POS_W'(1);
                        if (end_of_image)
                        begin
                            res_a.ev = EV_REJECTED;
                            push_cnt = 2'd1;
                        end
                    end
                end
                PH_RECORDS:
                begin
                    if (pos_reg == POS_W'(0))
                        fmt_next = data_byte;
                    if (pos_reg == POS_W'(1))
                        prot_next = data_byte;
                    if (pos_reg == POS_W'(2))
                        track_next = data_byte;
                    if (pos_reg == POS_W'(3))
                        sector_next = data_byte;
                    priority if (pos_reg < POS_W'(CRC_SPAN))
                    begin
                        crc_next = crc_byte(crc_reg, data_byte);
                        pos_next = pos_reg + POS_W'(1);
                    end
                    else if (pos_reg == POS_W'(CRC_SPAN))
                    begin
                        crc_hi_next = data_byte;
                        pos_next    = pos_reg + POS_W'(1);
                    end
                    else
                    begin
                        if (!rec_bad)
                        begin
                            total_next = sat_inc16(total_reg);
                            if (rec_ok)
                                valid_next = sat_inc16(valid_reg);
                            if (fmt_reg == FMT_FORMATTED || fmt_reg == FMT_PROTECTED)
                                formatted_next = sat_inc16(formatted_reg);
                            if (!seen_rd_reg)
                            begin
                                seen_set = 1'b1;
                                if (used_reg != TRACKS_MAX)
                                    used_next = used_reg + 7'd1;
                            end
                        end
                        res_a.ev        = rec_bad ? EV_SKIPPED : EV_COUNTED;
                        res_a.track     = track_reg;
                        res_a.sector    = sector_reg;
                        res_a.fmt       = fmt_reg;
                        res_a.prot      = prot_reg;
                        res_a.crc       = crc_reg;
                        res_a.ok        = rec_ok;
                        res_a.total     = total_next;
                        res_a.valid     = valid_next;
                        res_a.formatted = formatted_next;
                        res_a.tracks    = used_next;
                        push_cnt        = 2'd1;
                        pos_next        = '0;
                        crc_next        = CRC_INIT;
                    end
                    if (end_of_image)
                    begin
                        res_sum.ev        = EV_SUMMARY;
                        res_sum.total     = total_next;
                        res_sum.valid     = valid_next;
                        res_sum.formatted = formatted_next;
                        res_sum.tracks    = used_next;
                        if (push_cnt == 2'd0)
                            res_a = res_sum;
                        else
                            res_b = res_sum;
                        push_cnt = push_cnt + 2'd1;
                    end
                end
                PH_REJECTED:
                begin
                end
                default:
                begin
                end
            endcase

            if (push_cnt == 2'd1)
                res_a.last = 1'b1;
            if (push_cnt == 2'd2)
                res_b.last = 1'b1;

            if (end_of_image)
            begin
                phase_next      = PH_HEADER;
                pos_next        = '0;
                header_ok_next  = 1'b1;
                crc_next        = CRC_INIT;
                fmt_next        = '0;
                prot_next       = '0;
                track_next      = '0;
                sector_next     = '0;
                crc_hi_next     = '0;
                total_next      = '0;
                valid_next      = '0;
                formatted_next  = '0;
                used_next       = '0;
                clr_active_next = 1'b1;
                clr_idx_next    = '0;
            end
        end

        wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(push_cnt);
        rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(out_fire);
        cnt_next    = cnt_reg + FIFO_CNT_W'(push_cnt) - FIFO_CNT_W'(out_fire);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HEADER;
            pos_reg        <= '0;
            header_ok_reg  <= 1'b1;
            crc_reg        <= CRC_INIT;
            fmt_reg        <= '0;
            prot_reg       <= '0;
            track_reg      <= '0;
            sector_reg     <= '0;
            crc_hi_reg     <= '0;
            total_reg      <= '0;
            valid_reg      <= '0;
            formatted_reg  <= '0;
            used_reg       <= '0;
            clr_active_reg <= 1'b1;
            clr_idx_reg    <= '0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            cnt_reg        <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            pos_reg        <= pos_next;
            header_ok_reg  <= header_ok_next;
            crc_reg        <= crc_next;
            fmt_reg        <= fmt_next;
            prot_reg       <= prot_next;
            track_reg      <= track_next;
            sector_reg     <= sector_next;
            crc_hi_reg     <= crc_hi_next;
            total_reg      <= total_next;
            valid_reg      <= valid_next;
            formatted_reg  <= formatted_next;
            used_reg       <= used_next;
            clr_active_reg <= clr_active_next;
            clr_idx_reg    <= clr_idx_next;
            wr_ptr_reg     <= wr_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
            cnt_reg        <= cnt_next;
        end
    end

    // track map, read registered at the current record's track
    always_ff @(posedge clk)
    begin
        if (clr_active_reg)
            seen_mem[clr_idx_reg] <= 1'b0;
        else if (seen_set)
            seen_mem[track_reg[TRACK_IDX_W-1:0]] <= 1'b1;
        if (track_reg < 8'(NUM_TRACKS))
            seen_rd_reg <= seen_mem[track_reg[TRACK_IDX_W-1:0]];
    end

    // result queue payload
    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
            fifo_reg[wr_ptr_reg] <= res_a;
        if (push_cnt == 2'd2)
            fifo_reg[wr_ptr_reg + FIFO_PTR_W'(1)] <= res_b;
    end

    assign head              = fifo_reg[rd_ptr_reg];
    assign event_res         = head.ev;
    assign track_number      = head.track;
    assign sector_number     = head.sector;
    assign format_code       = head.fmt;
    assign protection_flags  = head.prot;
    assign computed_crc      = head.crc;
    assign crc_ok            = head.ok;
    assign sectors_total     = head.total;
    assign sectors_valid     = head.valid;
    assign sectors_formatted = head.formatted;
    assign tracks_used       = head.tracks;
    assign last_of_run       = head.last;

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_two_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (push_cnt == 2'd2) |-> (in_fire && end_of_image && phase_reg == PH_RECORDS))
        else $error("two results without image end");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && end_of_image) |=> (phase_reg == PH_HEADER && pos_reg == '0
                                       && total_reg == '0 && used_reg == '0))
        else $error("image end did not clear state");

    a_wipe_before_use: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && phase_reg == PH_RECORDS && pos_reg == POS_W'(CRC_SPAN + 1))
        |-> !clr_active_reg)
        else $error("record ended while track map wipe still running");

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= 7'(NUM_TRACKS))
        else $error("used track count above track count");

    a_count_order: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg <= total_reg) && (formatted_reg <= total_reg))
        else $error("sub count above total");

endmodule

`default_nettype wire
